// ===== sv/etf_pkg.sv =====
// Shared constants, types and command/status structs for the escape-time iterator.
// Used by etf_ctrl, etf_dpath and escape_time_fractal_iterator; depends on nothing.
package etf_pkg;

	// Fixed-point format of all coordinates and constants.
	localparam int unsigned FRAC_BITS  = 28;
	localparam int unsigned COORD_W    = 32;
	localparam int unsigned PROD_W     = 2 * COORD_W;
	localparam int unsigned LIMIT_W    = 16;
	localparam int unsigned COUNT_W    = LIMIT_W + 1;
	localparam int unsigned CFG_IDX_W  = 2;

	// Escape threshold: 4 at the scale of a squared value. It lies out of reach
	// when the format leaves no room for it, so nothing escapes then.
	localparam int unsigned ESC_SHIFT = 2 * FRAC_BITS + 2;
	localparam logic [PROD_W-1:0] ESC_LIMIT =
		(ESC_SHIFT < PROD_W) ? (PROD_W'(1) << ESC_SHIFT) : '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_JULIA_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C_REAL     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_C_IMAG     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 2'd3;

	// Which product the shared multiplier forms this cycle.
	typedef enum logic [1:0] {
		MUL_RR = 2'd0,
		MUL_II = 2'd1,
		MUL_RI = 2'd2
	} mul_sel_t;

	// Commands from the controller to the datapath and output register.
	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     check;
		logic     update;
		logic     out_load;
	} etf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic escaped;
		logic limit_hit;
	} etf_status_t;

endpackage

// ===== sv/etf_ctrl.sv =====
// Controller state machine for the escape-time iterator.
// Depends on etf_pkg; drives the datapath through etf_cmd_t.
module etf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_free,
	input  etf_pkg::etf_status_t status,
	output logic                 idle,
	output etf_pkg::etf_cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MRR  = 6'b000010,
		S_MII  = 6'b000100,
		S_MRI  = 6'b001000,
		S_UPD  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign idle = (state_q == S_IDLE);

	// Next state and commands: load a point, three products and an update per iteration, then hand the result out.
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.mul_sel  = etf_pkg::MUL_RR;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MRR;
				end
			end
			S_MRR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = etf_pkg::MUL_RR;
				state_d     = S_MII;
			end
			S_MII: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = etf_pkg::MUL_II;
				state_d     = S_MRI;
			end
			S_MRI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = etf_pkg::MUL_RI;
				cmd.check   = 1'b1;
				state_d     = S_UPD;
			end
			S_UPD: begin
				if (status.escaped) begin
					state_d = S_DONE;
				end else begin
					cmd.update = 1'b1;
					state_d    = status.limit_hit ? S_DONE : S_MRR;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/etf_dpath.sv =====
// Datapath of the escape-time iterator: z and c registers, one shared
// 32x32 multiplier, escape test and saturating update. Depends on etf_pkg.
module etf_dpath (
	input  logic                                  clk,
	input  etf_pkg::etf_cmd_t                     cmd,
	input  logic                                  julia_mode,
	input  logic signed [etf_pkg::COORD_W-1:0]    c_real,
	input  logic signed [etf_pkg::COORD_W-1:0]    c_imag,
	input  logic        [etf_pkg::LIMIT_W-1:0]    limit,
	input  logic signed [etf_pkg::COORD_W-1:0]    point_real,
	input  logic signed [etf_pkg::COORD_W-1:0]    point_imag,
	output etf_pkg::etf_status_t                  status,
	output logic        [etf_pkg::COUNT_W-1:0]    count,
	output logic                                  in_set
);

	localparam logic signed [etf_pkg::PROD_W-1:0] SAT_MAX =
		etf_pkg::PROD_W'({1'b0, {(etf_pkg::COORD_W-1){1'b1}}});
	localparam logic signed [etf_pkg::PROD_W-1:0] SAT_MIN = -SAT_MAX - 1;

	logic signed [etf_pkg::COORD_W-1:0] zr_q, zi_q, cr_q, ci_q;
	logic signed [etf_pkg::PROD_W-1:0]  rr_q, ii_q, ri_q, diff_q;
	logic                               esc_q;
	logic        [etf_pkg::COUNT_W-1:0] count_q;

	logic signed [etf_pkg::COORD_W-1:0] mul_a, mul_b;
	logic signed [etf_pkg::PROD_W-1:0]  prod;
	logic        [etf_pkg::PROD_W-1:0]  mag;
	logic signed [etf_pkg::PROD_W-1:0]  nr_w, ni_w;
	logic signed [etf_pkg::COORD_W-1:0] nr_sat, ni_sat;
	logic        [etf_pkg::COUNT_W-1:0] count_next;

	// Shared multiplier operands: zr*zr, zi*zi or zr*zi.
	always_comb begin
		case (cmd.mul_sel)
			etf_pkg::MUL_RR: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			etf_pkg::MUL_II: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			etf_pkg::MUL_RI: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Magnitude squared; both squares are non-negative and at most 2^62.
	assign mag = $unsigned(rr_q) + $unsigned(ii_q);

	// Floor shifts back to the coordinate scale, plus c, then saturate.
	assign nr_w = (diff_q >>> etf_pkg::FRAC_BITS) + etf_pkg::PROD_W'(cr_q);
	assign ni_w = (ri_q >>> (etf_pkg::FRAC_BITS - 1)) + etf_pkg::PROD_W'(ci_q);

	always_comb begin
		if (nr_w > SAT_MAX) begin
			nr_sat = SAT_MAX[etf_pkg::COORD_W-1:0];
		end else if (nr_w < SAT_MIN) begin
			nr_sat = SAT_MIN[etf_pkg::COORD_W-1:0];
		end else begin
			nr_sat = nr_w[etf_pkg::COORD_W-1:0];
		end
		if (ni_w > SAT_MAX) begin
			ni_sat = SAT_MAX[etf_pkg::COORD_W-1:0];
		end else if (ni_w < SAT_MIN) begin
			ni_sat = SAT_MIN[etf_pkg::COORD_W-1:0];
		end else begin
			ni_sat = ni_w[etf_pkg::COORD_W-1:0];
		end
	end

	assign count_next = count_q + etf_pkg::COUNT_W'(1);

	// Load the starting point, then iterate.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (julia_mode) begin
				zr_q <= point_real;
				zi_q <= point_imag;
				cr_q <= c_real;
				ci_q <= c_imag;
			end else begin
				zr_q <= '0;
				zi_q <= '0;
				cr_q <= point_real;
				ci_q <= point_imag;
			end
			count_q <= '0;
		end else if (cmd.update) begin
			zr_q    <= nr_sat;
			zi_q    <= ni_sat;
			count_q <= count_next;
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				etf_pkg::MUL_RR: rr_q <= prod;
				etf_pkg::MUL_II: ii_q <= prod;
				etf_pkg::MUL_RI: ri_q <= prod;
				default: ri_q <= prod;
			endcase
		end
		if (cmd.check) begin
			esc_q  <= (mag > etf_pkg::ESC_LIMIT);
			diff_q <= rr_q - ii_q;
		end
	end

	assign status.escaped   = esc_q;
	assign status.limit_hit = (count_next > etf_pkg::COUNT_W'(limit));
	assign count            = count_q;
	assign in_set           = (count_q > etf_pkg::COUNT_W'(limit));

endmodule

// ===== sv/escape_time_fractal_iterator.sv =====
// Top level of the escape-time iterator: configuration registers, output
// register, controller and datapath. Depends on etf_pkg, etf_ctrl, etf_dpath.
//
// Takes one complex point (signed Q4.28) per item and iterates z = z*z + c
// until |z|^2 exceeds 4 or the count passes iteration_limit, then returns
// the count and the in-set flag. One point is worked on at a time. In every
// iteration the three products zr*zr, zi*zi and zr*zi go one after another
// through a single 32x32 multiplier, followed by the saturating update. The
// default iteration limit is 256. A finished result waits in the output
// register, and the next point is accepted while it waits.
module escape_time_fractal_iterator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic        [etf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [etf_pkg::COORD_W-1:0]    cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [etf_pkg::COORD_W-1:0]    point_real,
	input  logic signed [etf_pkg::COORD_W-1:0]    point_imag,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic        [etf_pkg::COUNT_W-1:0]    iteration_count,
	output logic                                  in_set
);

	logic                                julia_mode_q;
	logic signed [etf_pkg::COORD_W-1:0]  c_real_q, c_imag_q;
	logic        [etf_pkg::LIMIT_W-1:0]  limit_q;

	logic                                out_valid_q;
	logic        [etf_pkg::COUNT_W-1:0]  count_out_q;
	logic                                in_set_out_q;

	etf_pkg::etf_cmd_t    cmd;
	etf_pkg::etf_status_t status;
	logic                 idle;
	logic                 out_free;
	logic [etf_pkg::COUNT_W-1:0] dp_count;
	logic                 dp_in_set;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			julia_mode_q <= 1'b0;
			c_real_q     <= '0;
			c_imag_q     <= '0;
			limit_q      <= etf_pkg::LIMIT_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				etf_pkg::REG_JULIA_MODE: julia_mode_q <= cfg_data[0];
				etf_pkg::REG_C_REAL:     c_real_q     <= cfg_data;
				etf_pkg::REG_C_IMAG:     c_imag_q     <= cfg_data;
				etf_pkg::REG_ITER_LIMIT: limit_q      <= cfg_data[etf_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !idle;

	etf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.status   (status),
		.idle     (idle),
		.cmd      (cmd)
	);

	etf_dpath u_dpath (
		.clk        (clk),
		.cmd        (cmd),
		.julia_mode (julia_mode_q),
		.c_real     (c_real_q),
		.c_imag     (c_imag_q),
		.limit      (limit_q),
		.point_real (point_real),
		.point_imag (point_imag),
		.status     (status),
		.count      (dp_count),
		.in_set     (dp_in_set)
	);

	// Output register: holds a finished item until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			count_out_q  <= dp_count;
			in_set_out_q <= dp_in_set;
		end
	end

	assign out_valid       = out_valid_q;
	assign iteration_count = count_out_q;
	assign in_set          = in_set_out_q;

	// An accepted item keeps the input side busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted but block not busy next cycle");

	// A result is written only into a free output register.
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("output register overwritten");

	// A point in the set has done at least one update.
	a_in_set_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && in_set_out_q) |-> (count_out_q != '0))
		else $error("in-set result with zero count");

	// An escaped point never reports a count beyond the 16-bit limit range.
	a_escape_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !in_set_out_q) |-> !count_out_q[etf_pkg::COUNT_W-1])
		else $error("escaped result with count above limit range");

endmodule
